### design/keyboard_shortcut_table_unit_macros.svh
// Assertion macros shared by the shortcut table RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef KEYBOARD_SHORTCUT_TABLE_UNIT_MACROS_SVH
`define KEYBOARD_SHORTCUT_TABLE_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/kst_pkg.sv
// Shared types, codes and key-matching functions of the shortcut table.
// No dependencies; used by kst_datapath, kst_ctrl and the top level.
`default_nettype none

package kst_pkg;

  localparam int unsigned MAX_SHORTCUTS_DEF = 16;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_LOOKUP   = 2'd0,
    FUNC_REGISTER = 2'd1,
    FUNC_REMOVE   = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  // Result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_MATCH  = 3'd1;
  localparam logic [2:0] STS_DUPLICATE = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_INVALID   = 3'd4;

  // Modifier bit positions within an entry
  localparam int unsigned MOD_CTRL_BIT = 0;
  localparam int unsigned MOD_ALT_BIT  = 1;
  localparam int unsigned MOD_META_BIT = 2;

  // Character constants
  localparam logic [7:0] KEY_NONE    = 8'h00;
  localparam logic [7:0] KEY_AT      = 8'h40;
  localparam logic [7:0] KEY_USCORE  = 8'h5F;
  localparam logic [7:0] KEY_UPPER_A = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
  localparam logic [7:0] KEY_LOWER_A = 8'h61;
  localparam logic [7:0] KEY_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CTRL_MASK   = 8'h1F;
  localparam logic [7:0] OWNER_NONE  = 8'h00;

  // One stored table entry
  typedef struct packed {
    logic [7:0] owner;
    logic [7:0] action;
    logic [2:0] mods;
    logic [7:0] key;
  } entry_t;

  // Input transaction payload
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key;
    logic [7:0] hotkey;
    logic       mod_ctrl;
    logic       mod_alt;
    logic       mod_meta;
    logic [7:0] action_handle;
    logic [7:0] owner_id;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] hit_action;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } sts_t;

  function automatic logic is_letter(input logic [7:0] k);
    return ((k >= KEY_UPPER_A) && (k <= KEY_UPPER_Z)) ||
           ((k >= KEY_LOWER_A) && (k <= KEY_LOWER_Z));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] k);
    logic [7:0] u;
    u = k;
    if ((k >= KEY_LOWER_A) && (k <= KEY_LOWER_Z)) begin
      u = k - CASE_OFFSET;
    end
    return u;
  endfunction

  // Does a stored entry answer a typed byte
  function automatic logic entry_hits(input logic [7:0] ek, input logic [2:0] mods,
                                      input logic [7:0] key);
    logic [7:0] u;
    logic       hit;
    u   = to_upper(ek);
    hit = 1'b0;
    if ((ek == KEY_NONE) || (key == KEY_NONE)) begin
      hit = 1'b0;
    end else if (mods[MOD_ALT_BIT] || mods[MOD_META_BIT]) begin
      hit = 1'b0;
    end else if (mods[MOD_CTRL_BIT]) begin
      hit = (u >= KEY_AT) && (u <= KEY_USCORE) && (key == (u & CTRL_MASK));
    end else begin
      hit = (ek == key) || (is_letter(ek) && is_letter(key) && (u == to_upper(key)));
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### design/kst_datapath.sv
// Datapath of the shortcut table: entry memory, scan counters, match logic, result register.
// Depends on kst_pkg and keyboard_shortcut_table_unit_macros.svh; driven by kst_ctrl.
`default_nettype none
`include "keyboard_shortcut_table_unit_macros.svh"

module kst_datapath #(
  parameter int unsigned MAX_SHORTCUTS = kst_pkg::MAX_SHORTCUTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kst_pkg::in_t  in_data,
  input  wire kst_pkg::cmd_t cmd,
  output kst_pkg::sts_t      sts,
  output kst_pkg::out_t      out_data
);

  localparam int unsigned IW = (MAX_SHORTCUTS > 1) ? $clog2(MAX_SHORTCUTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SHORTCUTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SHORTCUTS);

  // Entry store, insertion order
  kst_pkg::entry_t slot_mem_r [MAX_SHORTCUTS];

  kst_pkg::in_t    req_r;
  kst_pkg::entry_t rd_ent_r;
  kst_pkg::out_t   out_r, out_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]   wr_idx_r, wr_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic            found_r, found_nxt;
  logic [7:0]      hit_act_r, hit_act_nxt;

  logic [2:0]      req_mods;
  logic            is_lookup, is_reg, is_rem, is_clr;
  logic            reg_invalid, scan_need;
  logic            rd_en, eval, ent_hit, ent_dup, found_set, keep_we, append_ok;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  kst_pkg::entry_t mem_wdata, new_ent;

  // Request decode
  assign req_mods    = {req_r.mod_meta, req_r.mod_alt, req_r.mod_ctrl};
  assign is_lookup   = (req_r.func == kst_pkg::FUNC_LOOKUP);
  assign is_reg      = (req_r.func == kst_pkg::FUNC_REGISTER);
  assign is_rem      = (req_r.func == kst_pkg::FUNC_REMOVE);
  assign is_clr      = (req_r.func == kst_pkg::FUNC_CLEAR);
  assign reg_invalid = (req_r.hotkey == kst_pkg::KEY_NONE) && (req_mods == 3'b000);
  assign scan_need   = is_lookup || (is_reg && !reg_invalid) ||
                       (is_rem && (req_r.owner_id != kst_pkg::OWNER_NONE));

  // Scan: one read issued per cycle, the entry read last cycle is evaluated
  assign rd_en     = cmd.scan && scan_need && !found_r && (rd_idx_r < cnt_r);
  assign eval      = rd_vld_r && !found_r;
  assign ent_hit   = kst_pkg::entry_hits(rd_ent_r.key, rd_ent_r.mods, req_r.key);
  assign ent_dup   = (rd_ent_r.mods == req_mods) &&
                     (kst_pkg::to_upper(rd_ent_r.key) ==
                      kst_pkg::to_upper(req_r.hotkey));
  assign found_set = eval && ((is_lookup && ent_hit) || (is_reg && ent_dup));
  assign keep_we   = eval && is_rem && (rd_ent_r.owner != req_r.owner_id);
  assign append_ok = cmd.commit && is_reg && !reg_invalid && !found_r && (cnt_r < MAX_CNT);

  assign sts.scan_done = !rd_vld_r && (found_r || !scan_need || (rd_idx_r >= cnt_r));

  // Memory write: compaction during a removal, append at commit
  assign new_ent   = '{owner: req_r.owner_id, action: req_r.action_handle,
                       mods: req_mods, key: req_r.hotkey};
  assign mem_we    = keep_we || append_ok;
  assign mem_waddr = append_ok ? cnt_r[IW-1:0] : wr_idx_r[IW-1:0];
  assign mem_wdata = append_ok ? new_ent : rd_ent_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_ent_r <= slot_mem_r[rd_idx_r[IW-1:0]];
    end
  end

  // Next-state for scan control and result
  always_comb begin
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    rd_vld_nxt  = rd_en;
    found_nxt   = found_r;
    hit_act_nxt = hit_act_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    if (cmd.load) begin
      rd_idx_nxt  = '0;
      wr_idx_nxt  = '0;
      rd_vld_nxt  = 1'b0;
      found_nxt   = 1'b0;
      hit_act_nxt = 8'd0;
    end else begin
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      if (keep_we) begin
        wr_idx_nxt = wr_idx_r + 1'b1;
      end
      if (found_set) begin
        found_nxt   = 1'b1;
        hit_act_nxt = rd_ent_r.action;
      end
    end
    if (cmd.commit) begin
      out_nxt.status     = kst_pkg::STS_OK;
      out_nxt.hit_action = 8'd0;
      if (is_lookup) begin
        if (found_r) begin
          out_nxt.hit_action = hit_act_r;
        end else begin
          out_nxt.status = kst_pkg::STS_NO_MATCH;
        end
      end else if (is_reg) begin
        if (reg_invalid) begin
          out_nxt.status = kst_pkg::STS_INVALID;
        end else if (found_r) begin
          out_nxt.status = kst_pkg::STS_DUPLICATE;
        end else if (cnt_r >= MAX_CNT) begin
          out_nxt.status = kst_pkg::STS_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (is_rem) begin
        if (req_r.owner_id != kst_pkg::OWNER_NONE) begin
          cnt_nxt = wr_idx_r;
        end
      end else if (is_clr) begin
        cnt_nxt = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    hit_act_r <= hit_act_nxt;
    out_r     <= out_nxt;
  end

  assign out_data = out_r;

  `KST_ASSERT(a_cnt_bound, cnt_r <= MAX_CNT, "entry count beyond table size")
  `KST_ASSERT(a_compact_behind, keep_we |-> (wr_idx_r < rd_idx_r), "compaction overtook read")
  `KST_ASSERT_NEXT(a_found_kind, found_set, is_lookup || is_reg, "match flagged on wrong op")

endmodule

`default_nettype wire

### design/kst_ctrl.sv
// Controller of the shortcut table: sequences accept, scan and commit, owns both handshakes.
// Depends on kst_pkg and keyboard_shortcut_table_unit_macros.svh; commands kst_datapath.
`default_nettype none
`include "keyboard_shortcut_table_unit_macros.svh"

module kst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire kst_pkg::sts_t sts,
  output kst_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Result register can take a new transaction
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `KST_ASSERT_NEXT(a_accept_scan, in_valid && !in_stall, state_r == ST_SCAN, "scan not started")
  `KST_ASSERT(a_commit_free, cmd.commit |-> slot_free, "commit over an unread result")
  `KST_ASSERT(a_rise_commit, $rose(out_valid_r) |-> $past(cmd.commit), "result without commit")

endmodule

`default_nettype wire

### design/keyboard_shortcut_table_unit.sv
// Top level of the keyboard shortcut table: controller plus datapath.
// Depends on kst_pkg, kst_ctrl and kst_datapath.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_stall  | in_data  (func, key, hotkey, mods, ...)
//   out     | out_valid/out_stall| out_data (status, hit_action)
//
// One transaction at a time; the scan reads one entry a cycle from the entry memory.
// Lookup, register and remove scan the stored entries before their result is presented;
// a hit or duplicate ends the scan early, and clear does not scan. The next transaction
// is taken once the result has been committed.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// An earlier result held by out_stall does not block acceptance; the commit waits for it.
`default_nettype none

module keyboard_shortcut_table_unit #(
  parameter int unsigned MAX_SHORTCUTS = kst_pkg::MAX_SHORTCUTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire kst_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output kst_pkg::out_t     out_data
);

  kst_pkg::cmd_t cmd;
  kst_pkg::sts_t sts;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kst_datapath #(
    .MAX_SHORTCUTS (MAX_SHORTCUTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### dv/keyboard_shortcut_table_unit_test.sv
// Self-checking testbench for keyboard_shortcut_table_unit: queue-fed driver, monitor
// and an in-bench table predictor checked transaction by transaction.
// Depends on kst_pkg and the keyboard_shortcut_table_unit RTL only.
`default_nettype none

module keyboard_shortcut_table_unit_test;

  localparam int unsigned TABLE_DEPTH  = kst_pkg::MAX_SHORTCUTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned MAX_WAIT     = 16;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  localparam logic [2:0] MODS_NONE = 3'b000;
  localparam logic [2:0] MODS_CTRL = 3'b001 << kst_pkg::MOD_CTRL_BIT;
  localparam logic [2:0] MODS_ALT  = 3'b001 << kst_pkg::MOD_ALT_BIT;
  localparam logic [2:0] MODS_META = 3'b001 << kst_pkg::MOD_META_BIT;

  typedef struct packed {
    logic [7:0] key;
    logic [2:0] mods;
  } shortcut_t;

  logic          clk      = 1'b0;
  logic          rst_n    = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  kst_pkg::in_t  in_data  = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  kst_pkg::out_t out_data;

  // Stimulus and expected outcomes
  kst_pkg::in_t  pending_items[$];
  kst_pkg::out_t expected_results[$];

  // Predicted table contents
  logic [7:0] tbl_key[TABLE_DEPTH];
  logic [2:0] tbl_mods[TABLE_DEPTH];
  logic [7:0] tbl_action[TABLE_DEPTH];
  logic [7:0] tbl_owner[TABLE_DEPTH];
  int unsigned tbl_count = 0;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned drv_gap      = 0;
  int unsigned mon_hold     = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;

  keyboard_shortcut_table_unit #(
    .MAX_SHORTCUTS(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Key helpers
  function automatic logic is_alpha(input logic [7:0] k);
    return ((k >= kst_pkg::KEY_UPPER_A) && (k <= kst_pkg::KEY_UPPER_Z)) ||
           ((k >= kst_pkg::KEY_LOWER_A) && (k <= kst_pkg::KEY_LOWER_Z));
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] k);
    if ((k >= kst_pkg::KEY_LOWER_A) && (k <= kst_pkg::KEY_LOWER_Z)) begin
      return k - kst_pkg::CASE_OFFSET;
    end
    return k;
  endfunction

  // Whether a stored shortcut answers a typed byte
  function automatic logic entry_answers(input logic [7:0] ek, input logic [2:0] mods,
                                         input logic [7:0] k);
    logic [7:0] up;
    logic       ans;
    up = fold_upper(ek);
    if ((ek == kst_pkg::KEY_NONE) || (k == kst_pkg::KEY_NONE) ||
        mods[kst_pkg::MOD_ALT_BIT] || mods[kst_pkg::MOD_META_BIT]) begin
      ans = 1'b0;
    end else if (mods[kst_pkg::MOD_CTRL_BIT]) begin
      ans = (up >= kst_pkg::KEY_AT) && (up <= kst_pkg::KEY_USCORE) &&
            (k == (up & kst_pkg::CTRL_MASK));
    end else begin
      ans = (ek == k) || (is_alpha(ek) && is_alpha(k) && (up == fold_upper(k)));
    end
    return ans;
  endfunction

  // Table predictor: applies one transaction and returns its outcome
  function automatic kst_pkg::out_t table_outcome(input kst_pkg::in_t t);
    kst_pkg::out_t r;
    logic [2:0]    m;
    logic [7:0]    norm;
    logic          found;
    int unsigned   w;
    r.status     = kst_pkg::STS_OK;
    r.hit_action = '0;
    m     = '0;
    m[kst_pkg::MOD_CTRL_BIT] = t.mod_ctrl;
    m[kst_pkg::MOD_ALT_BIT]  = t.mod_alt;
    m[kst_pkg::MOD_META_BIT] = t.mod_meta;
    found = 1'b0;
    w     = 0;
    case (t.func)
      kst_pkg::FUNC_LOOKUP: begin
        r.status = kst_pkg::STS_NO_MATCH;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (!found && entry_answers(tbl_key[i], tbl_mods[i], t.key)) begin
            found        = 1'b1;
            r.status     = kst_pkg::STS_OK;
            r.hit_action = tbl_action[i];
          end
        end
      end
      kst_pkg::FUNC_REGISTER: begin
        if ((t.hotkey == kst_pkg::KEY_NONE) && (m == MODS_NONE)) begin
          r.status = kst_pkg::STS_INVALID;
        end else begin
          norm = fold_upper(t.hotkey);
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if ((tbl_mods[i] == m) && (fold_upper(tbl_key[i]) == norm)) begin
              found = 1'b1;
            end
          end
          if (found) begin
            r.status = kst_pkg::STS_DUPLICATE;
          end else if (tbl_count >= TABLE_DEPTH) begin
            r.status = kst_pkg::STS_FULL;
          end else begin
            tbl_key[tbl_count]    = t.hotkey;
            tbl_mods[tbl_count]   = m;
            tbl_action[tbl_count] = t.action_handle;
            tbl_owner[tbl_count]  = t.owner_id;
            tbl_count++;
          end
        end
      end
      kst_pkg::FUNC_REMOVE: begin
        if (t.owner_id != kst_pkg::OWNER_NONE) begin
          // compact survivors towards slot 0, order kept
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_owner[i] != t.owner_id) begin
              tbl_key[w]    = tbl_key[i];
              tbl_mods[w]   = tbl_mods[i];
              tbl_action[w] = tbl_action[i];
              tbl_owner[w]  = tbl_owner[i];
              w++;
            end
          end
          tbl_count = w;
        end
      end
      default: begin
        tbl_count = 0;
      end
    endcase
    return r;
  endfunction

  // Stimulus helpers
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_owner();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return 8'($urandom_range(1, 4));
    end else if (r == 7) begin
      return kst_pkg::OWNER_NONE;
    end
    return rand_byte();
  endfunction

  function automatic shortcut_t pick_shortcut();
    shortcut_t   sc;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      sc.key = kst_pkg::KEY_UPPER_A + 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) begin
        sc.key = sc.key + kst_pkg::CASE_OFFSET;
      end
    end else if (r < 7) begin
      sc.key = kst_pkg::KEY_AT + 8'($urandom_range(0, 31));
    end else if (r < 9) begin
      sc.key = rand_byte();
    end else begin
      sc.key = kst_pkg::KEY_NONE;
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      sc.mods = MODS_NONE;
    end else if (r < 9) begin
      sc.mods = MODS_CTRL;
    end else begin
      sc.mods = 3'($urandom_range(0, 7));
    end
    return sc;
  endfunction

  // Unused fields of a transaction carry random noise
  task automatic queue_item(input kst_pkg::func_t f, input logic [7:0] k,
                            input logic [7:0] sk, input logic [2:0] m,
                            input logic [7:0] act, input logic [7:0] own);
    logic [63:0]  noise;
    kst_pkg::in_t t;
    noise = {$urandom, $urandom};
    t     = noise[$bits(kst_pkg::in_t)-1:0];
    t.func = f;
    case (f)
      kst_pkg::FUNC_LOOKUP: begin
        t.key = k;
      end
      kst_pkg::FUNC_REGISTER: begin
        t.hotkey        = sk;
        t.mod_ctrl      = m[kst_pkg::MOD_CTRL_BIT];
        t.mod_alt       = m[kst_pkg::MOD_ALT_BIT];
        t.mod_meta      = m[kst_pkg::MOD_META_BIT];
        t.action_handle = act;
        t.owner_id      = own;
      end
      kst_pkg::FUNC_REMOVE: begin
        t.owner_id = own;
      end
      default: begin
      end
    endcase
    pending_items.push_back(t);
  endtask

  // Wait drawn per transaction; every fourth stretch of 80 runs without idling
  function automatic int unsigned draw_wait(input int unsigned seq);
    if (((seq / 80) % 4) == 3) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Driver: presents queued items, holds them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap  = draw_wait(0);
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(table_outcome(in_data));
        items_sent++;
        drv_gap = draw_wait(items_sent);
      end
      if ((drv_gap != 0) || (pending_items.size() == 0)) begin
        in_valid <= 1'b0;
        if (drv_gap != 0) begin
          drv_gap--;
        end
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    kst_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_hold  = draw_wait(0);
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d hit_action %02h", $time,
                   out_data.status, out_data.hit_action);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_data.status);
            error_count++;
          end
          if (out_data.hit_action !== want.hit_action) begin
            $display("%0t: hit_action expected %02h, got %02h", $time, want.hit_action,
                     out_data.hit_action);
            error_count++;
          end
        end
        results_seen++;
        mon_hold = draw_wait(results_seen);
      end
      if (mon_hold != 0) begin
        out_stall <= 1'b1;
        mon_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    shortcut_t   sc;
    shortcut_t   known[$];
    int unsigned random_target;
    int unsigned sel;
    logic [7:0]  k;

    // Directed: special cases and field extremes
    // empty table
    queue_item(kst_pkg::FUNC_LOOKUP, kst_pkg::KEY_NONE, 8'h00, MODS_NONE, 8'h00, 8'h00);
    // all-zero shortcut, then zero key with ctrl
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, kst_pkg::KEY_NONE, MODS_NONE, 8'h55, 8'h01);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, kst_pkg::KEY_NONE, MODS_CTRL, 8'h00, 8'h01);
    // 'a', looked up as 'A', then a duplicate of it
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h61, MODS_NONE, 8'hFF, 8'hFF);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h41, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h41, MODS_NONE, 8'h12, 8'h02);
    // ctrl-c
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h63, MODS_CTRL, 8'h11, 8'h01);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h03, 8'h00, MODS_NONE, 8'h00, 8'h00);
    // alt-x and meta-y never hit
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h78, MODS_ALT,  8'h21, 8'h02);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h79, MODS_META, 8'h22, 8'h02);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h78, 8'h00, MODS_NONE, 8'h00, 8'h00);
    // ctrl on a key outside the control range
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'h7E, MODS_CTRL, 8'h33, 8'h03);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h1E, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, kst_pkg::KEY_AT, MODS_CTRL, 8'h44, 8'h03);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, kst_pkg::KEY_USCORE, MODS_CTRL, 8'h45, 8'h03);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h1F, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'hFF, MODS_NONE, 8'h01, 8'h04);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'hFF, 8'h00, MODS_NONE, 8'h00, 8'h00);
    // every modifier
    queue_item(kst_pkg::FUNC_REGISTER, 8'h00, 8'hFF, 3'b111, 8'h02, 8'h04);
    queue_item(kst_pkg::FUNC_REMOVE, 8'h00, 8'h00, MODS_NONE, 8'h00, kst_pkg::OWNER_NONE);
    queue_item(kst_pkg::FUNC_REMOVE,   8'h00, 8'h00, MODS_NONE, 8'h00, 8'h01);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h03, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h61, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_CLEAR,    8'h00, 8'h00, MODS_NONE, 8'h00, 8'h00);
    queue_item(kst_pkg::FUNC_LOOKUP,   8'h61, 8'h00, MODS_NONE, 8'h00, 8'h00);

    // Random: episodes of registrations followed by mixed traffic on them
    random_target = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < random_target) begin
      known.delete();
      if ($urandom_range(0, 2) == 0) begin
        queue_item(kst_pkg::FUNC_CLEAR, rand_byte(), rand_byte(), MODS_NONE, rand_byte(),
                   rand_byte());
      end
      repeat ($urandom_range(0, 20)) begin
        sc = pick_shortcut();
        known.push_back(sc);
        queue_item(kst_pkg::FUNC_REGISTER, rand_byte(), sc.key, sc.mods, rand_byte(),
                   pick_owner());
      end
      repeat ($urandom_range(5, 30)) begin
        if (known.size() > 0) begin
          sc = known[$urandom_range(0, known.size() - 1)];
        end else begin
          sc = pick_shortcut();
        end
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          case ($urandom_range(0, 3))
            0:       k = sc.key;
            1:       k = sc.key ^ kst_pkg::CASE_OFFSET;
            2:       k = fold_upper(sc.key) & kst_pkg::CTRL_MASK;
            default: k = rand_byte();
          endcase
          queue_item(kst_pkg::FUNC_LOOKUP, k, 8'h00, MODS_NONE, 8'h00, 8'h00);
        end else if (sel < 70) begin
          if ($urandom_range(0, 1) == 0) begin
            sc.key = sc.key ^ (is_alpha(sc.key) ? kst_pkg::CASE_OFFSET : 8'h00);
          end else begin
            sc = pick_shortcut();
            known.push_back(sc);
          end
          queue_item(kst_pkg::FUNC_REGISTER, rand_byte(), sc.key, sc.mods, rand_byte(),
                     pick_owner());
        end else if (sel < 80) begin
          queue_item(kst_pkg::FUNC_REMOVE, 8'h00, 8'h00, MODS_NONE, 8'h00, pick_owner());
        end else if (sel < 85) begin
          queue_item(kst_pkg::FUNC_CLEAR, 8'h00, 8'h00, MODS_NONE, 8'h00, 8'h00);
        end else begin
          queue_item(kst_pkg::func_t'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                     3'($urandom_range(0, 7)), rand_byte(), rand_byte());
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while ((pending_items.size() != 0) || in_valid || (expected_results.size() != 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
